// File: rtl/ths_pkg.sv
package ths_pkg;

    localparam int SLOTS = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_BEAT  = 2'd1;
    localparam logic [1:0] CMD_UNREG = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_PERIOD  = 2'd1;
    localparam logic [1:0] REG_WDG_RDY = 2'd2;

    localparam logic [31:0] TIMEOUT_RST = 32'd1000;
    localparam logic [15:0] PERIOD_RST  = 16'd100;

    typedef enum logic [2:0] {
        K_TICK,
        K_BEAT,
        K_UNREG,
        K_IGNORE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
    } t_op;

endpackage

// File: rtl/task_heartbeat_supervisor_core.sv
// Heartbeat supervisor: a beat (cmd 1) stamps the current millisecond count into a task
// slot and arms it, an unregister (cmd 2) disarms it, and a tick (cmd 0) advances time and,
// every check_period_ms ticks, checks all armed slots. Each request gives exactly one result.
// Beats, unregisters, unused codes and ticks without a check are handled from the idle state;
// a tick that runs a check passes through the scan, last and done states, the scan reading
// one slot a cycle through the single read port of the beat-time store. A two-entry request
// queue lets the input side keep going while a check or a stalled result holds the back end.
// The user must write registers via the plain write port while idle; the block does not enforce it.
module task_heartbeat_supervisor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_check_done,
    output logic        o_refresh,
    output logic        o_stale_found,
    output logic [4:0]  o_stale_slot,
    output logic        o_slot_ignored
);

    logic         push;
    logic         full;
    logic         pop;
    logic         q_valid;
    ths_pkg::t_op f_op;
    ths_pkg::t_op q_op;

    ths_front u_front (
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_slot     (i_slot),
        .i_full     (full),
        .o_push     (push),
        .o_op       (f_op)
    );

    ths_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    ths_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_op         (q_op),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_check_done   (o_check_done),
        .o_refresh      (o_refresh),
        .o_stale_found  (o_stale_found),
        .o_stale_slot   (o_stale_slot),
        .o_slot_ignored (o_slot_ignored)
    );

endmodule

// File: rtl/ths_front.sv
module ths_front (
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_slot,
    input  logic              i_full,
    output logic              o_push,
    output ths_pkg::t_op      o_op
);

    assign o_in_ready = i_rst_n && !i_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_op.slot = i_slot[ths_pkg::SLOT_W-1:0];
        case (i_cmd)
            ths_pkg::CMD_TICK: begin
                o_op.kind = ths_pkg::K_TICK;
            end
            ths_pkg::CMD_BEAT, ths_pkg::CMD_UNREG: begin
                if (32'(i_slot) >= 32'(ths_pkg::SLOTS)) begin
                    o_op.kind = ths_pkg::K_IGNORE;
                end else if (i_cmd == ths_pkg::CMD_BEAT) begin
                    o_op.kind = ths_pkg::K_BEAT;
                end else begin
                    o_op.kind = ths_pkg::K_UNREG;
                end
            end
            default: begin
                o_op.kind = ths_pkg::K_NOP;
            end
        endcase
    end

endmodule

// File: rtl/ths_queue.sv
module ths_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  ths_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output ths_pkg::t_op o_op
);

    ths_pkg::t_op r_ent [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/ths_back.sv
module ths_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_q_valid,
    input  ths_pkg::t_op i_q_op,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic         o_check_done,
    output logic         o_refresh,
    output logic         o_stale_found,
    output logic [4:0]   o_stale_slot,
    output logic         o_slot_ignored
);

    localparam int SW = ths_pkg::SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [31:0]           r_timeout;
    logic [15:0]           r_period_cfg;
    logic                  r_wdg_rdy;
    logic [31:0]           r_now;
    logic [15:0]           r_period;
    logic [ths_pkg::SLOTS-1:0] r_active;
    logic [31:0]           r_mem [ths_pkg::SLOTS];
    logic [SW-1:0]         r_scan_idx;
    logic [31:0]           r_rd_data;
    logic [SW-1:0]         r_rd_idx;
    logic                  r_rd_act;
    logic                  r_rd_vld;
    logic                  r_found;
    logic [SW-1:0]         r_which;

    logic        out_free;
    logic        out_set;
    logic [31:0] n_now;
    logic [15:0] n_period;
    logic        do_check;
    logic        stale;

    assign out_free = !o_out_valid || i_out_ready;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid && out_free;
    assign n_now    = r_now + 32'd1;
    assign n_period = r_period + 16'd1;
    assign do_check = (n_period >= r_period_cfg);
    assign stale    = r_rd_act && ((r_rd_data == 32'd0) || ((r_now - r_rd_data) > r_timeout));
    // a new result is registered into the output at the end of this cycle
    assign out_set  = (o_pop && !((i_q_op.kind == ths_pkg::K_TICK) && do_check)) ||
                      ((r_state == S_DONE) && out_free);

    // beat time store, one read port for the scan
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_op.kind == ths_pkg::K_BEAT) begin
            r_mem[i_q_op.slot] <= r_now;
        end
        r_rd_data <= r_mem[r_scan_idx];
        r_rd_idx  <= r_scan_idx;
        r_rd_act  <= r_active[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_timeout      <= ths_pkg::TIMEOUT_RST;
            r_period_cfg   <= ths_pkg::PERIOD_RST;
            r_wdg_rdy      <= 1'b1;
            r_now          <= 32'd0;
            r_period       <= 16'd0;
            r_active       <= '0;
            r_scan_idx     <= '0;
            r_rd_vld       <= 1'b0;
            r_found        <= 1'b0;
            r_which        <= '0;
            o_out_valid    <= 1'b0;
            o_check_done   <= 1'b0;
            o_refresh      <= 1'b0;
            o_stale_found  <= 1'b0;
            o_stale_slot   <= 5'd0;
            o_slot_ignored <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ths_pkg::REG_TIMEOUT: r_timeout    <= i_cfg_data;
                    ths_pkg::REG_PERIOD:  r_period_cfg <= i_cfg_data[15:0];
                    ths_pkg::REG_WDG_RDY: r_wdg_rdy    <= i_cfg_data[0];
                    default:              r_wdg_rdy    <= r_wdg_rdy;
                endcase
            end

            if (i_out_ready && !out_set) begin
                o_out_valid <= 1'b0;
            end

            r_rd_vld <= (r_state == S_SCAN);
            if (r_rd_vld && stale && !r_found) begin
                r_found <= 1'b1;
                r_which <= r_rd_idx;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        o_check_done   <= 1'b0;
                        o_refresh      <= 1'b0;
                        o_stale_found  <= 1'b0;
                        o_stale_slot   <= 5'd0;
                        o_slot_ignored <= 1'b0;
                        case (i_q_op.kind)
                            ths_pkg::K_TICK: begin
                                r_now <= n_now;
                                if (do_check) begin
                                    r_period   <= 16'd0;
                                    r_scan_idx <= '0;
                                    r_found    <= 1'b0;
                                    r_which    <= '0;
                                    r_state    <= S_SCAN;
                                end else begin
                                    r_period    <= n_period;
                                    o_out_valid <= 1'b1;
                                end
                            end
                            ths_pkg::K_BEAT: begin
                                r_active[i_q_op.slot] <= 1'b1;
                                o_out_valid           <= 1'b1;
                            end
                            ths_pkg::K_UNREG: begin
                                r_active[i_q_op.slot] <= 1'b0;
                                o_out_valid           <= 1'b1;
                            end
                            ths_pkg::K_IGNORE: begin
                                o_slot_ignored <= 1'b1;
                                o_out_valid    <= 1'b1;
                            end
                            default: begin
                                o_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx == SW'(ths_pkg::SLOTS - 1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_scan_idx <= r_scan_idx + SW'(1);
                    end
                end
                S_LAST: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid   <= 1'b1;
                        o_check_done  <= 1'b1;
                        o_refresh     <= !r_found && r_wdg_rdy;
                        o_stale_found <= r_found;
                        o_stale_slot  <= 5'(r_which);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/ths_checker.sv
module ths_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_check_done,
    input logic       o_refresh,
    input logic       o_stale_found,
    input logic [4:0] o_stale_slot,
    input logic       o_slot_ignored
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_refresh_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refresh |-> o_check_done && !o_stale_found)
        else $error("refresh without a clean check");

    a_stale_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stale_found |-> o_check_done && !o_slot_ignored)
        else $error("stale report outside a check");

    a_stale_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_stale_found |-> o_stale_slot == 5'd0)
        else $error("stale slot set without a stale report");

endmodule

bind task_heartbeat_supervisor_core ths_checker u_ths_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_check_done   (o_check_done),
    .o_refresh      (o_refresh),
    .o_stale_found  (o_stale_found),
    .o_stale_slot   (o_stale_slot),
    .o_slot_ignored (o_slot_ignored)
);

// File: tb/sv/task_heartbeat_supervisor_core_test.sv
module task_heartbeat_supervisor_core_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic       check_done;
        logic       refresh;
        logic       stale_found;
        logic [4:0] stale_slot;
        logic       slot_ignored;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = '0;
    logic [7:0]  i_slot = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_check_done;
    logic        o_refresh;
    logic        o_stale_found;
    logic [4:0]  o_stale_slot;
    logic        o_slot_ignored;

    // supervisor shadow state
    logic [31:0] now_ms;
    logic [15:0] ticks_since_check;
    logic [31:0] last_beat [ths_pkg::SLOTS];
    logic        slot_armed [ths_pkg::SLOTS];
    logic [31:0] cfg_timeout;
    logic [15:0] cfg_period;
    logic        cfg_wdg_ready;

    t_outcome pending_outcomes[$];
    int       error_count = 0;
    logic     gaps_on = 1'b1;

    task_heartbeat_supervisor_core DUT (.*);

    always #4 i_clk = ~i_clk;

    function automatic t_outcome supervise_step(logic [1:0] cmd, logic [7:0] slot);
        t_outcome   res;
        logic [31:0] age;
        res = '0;
        if (cmd == ths_pkg::CMD_TICK) begin
            now_ms = now_ms + 32'd1;
            ticks_since_check = ticks_since_check + 16'd1;
            if (ticks_since_check >= cfg_period) begin
                ticks_since_check = '0;
                res.check_done = 1'b1;
                for (int i = 0; i < ths_pkg::SLOTS; i++) begin
                    if (slot_armed[i] && !res.stale_found) begin
                        age = now_ms - last_beat[i];
                        if (last_beat[i] == 32'd0 || age > cfg_timeout) begin
                            res.stale_found = 1'b1;
                            res.stale_slot = 5'(i);
                        end
                    end
                end
                res.refresh = !res.stale_found && cfg_wdg_ready;
            end
        end else if (cmd == ths_pkg::CMD_BEAT || cmd == ths_pkg::CMD_UNREG) begin
            if (int'(slot) >= ths_pkg::SLOTS) begin
                res.slot_ignored = 1'b1;
            end else if (cmd == ths_pkg::CMD_BEAT) begin
                last_beat[slot] = now_ms;
                slot_armed[slot] = 1'b1;
            end else begin
                slot_armed[slot] = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ths_pkg::REG_TIMEOUT: cfg_timeout = data;
            ths_pkg::REG_PERIOD:  cfg_period = data[15:0];
            ths_pkg::REG_WDG_RDY: cfg_wdg_ready = data[0];
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] slot);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_slot <= slot;
        do @(posedge i_clk); while (!o_in_ready);
        pending_outcomes.push_back(supervise_step(cmd, slot));
    endtask

    // hold off new requests until every result is back and the scan has settled
    task automatic drain_outcomes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (2 * ths_pkg::SLOTS + 6) @(posedge i_clk);
    endtask

    task automatic test_beat_at_time_zero();
        write_register(ths_pkg::REG_PERIOD, 32'd1);
        write_register(ths_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
        write_register(ths_pkg::REG_WDG_RDY, 32'd1);
        send_request(ths_pkg::CMD_BEAT, 8'd0);
        send_request(ths_pkg::CMD_BEAT, 8'(ths_pkg::SLOTS - 1));
        send_request(ths_pkg::CMD_TICK, 8'd0);
        send_request(ths_pkg::CMD_UNREG, 8'd0);
        send_request(ths_pkg::CMD_TICK, 8'hFF);
        send_request(ths_pkg::CMD_UNREG, 8'(ths_pkg::SLOTS - 1));
        send_request(ths_pkg::CMD_TICK, 8'd0);
    endtask

    task automatic test_ignored_requests();
        send_request(ths_pkg::CMD_BEAT, 8'(ths_pkg::SLOTS));
        send_request(ths_pkg::CMD_BEAT, 8'hFF);
        send_request(ths_pkg::CMD_UNREG, 8'h80);
        send_request(ths_pkg::CMD_UNREG, 8'h55);
        send_request(CMD_UNUSED, 8'd3);
        send_request(CMD_UNUSED, 8'hAA);
    endtask

    task automatic test_zero_timeout_and_period();
        drain_outcomes();
        write_register(ths_pkg::REG_TIMEOUT, 32'd0);
        write_register(ths_pkg::REG_PERIOD, 32'd0);
        write_register(ths_pkg::REG_WDG_RDY, 32'd0);
        send_request(ths_pkg::CMD_BEAT, 8'd3);
        send_request(ths_pkg::CMD_TICK, 8'd0);
        send_request(ths_pkg::CMD_UNREG, 8'd3);
        send_request(ths_pkg::CMD_TICK, 8'd0);
    endtask

    task automatic test_period_shortened();
        drain_outcomes();
        write_register(ths_pkg::REG_PERIOD, 32'h0000_FFFF);
        write_register(ths_pkg::REG_TIMEOUT, 32'd1);
        write_register(ths_pkg::REG_WDG_RDY, 32'd1);
        repeat (3) send_request(ths_pkg::CMD_TICK, 8'd0);
        drain_outcomes();
        write_register(ths_pkg::REG_PERIOD, 32'd2);
        send_request(ths_pkg::CMD_TICK, 8'd0);
    endtask

    task automatic test_random_traffic();
        int counted;
        int phase_len;
        int pick;
        logic [31:0] timeout_val;
        logic [31:0] period_val;
        counted = 0;
        while (counted < 1430) begin
            drain_outcomes();
            pick = $urandom_range(0, 9);
            if (pick == 0) timeout_val = 32'd1;
            else if (pick == 1) timeout_val = 32'hFFFF_FFFF;
            else if (pick < 6) timeout_val = $urandom_range(2, 40);
            else timeout_val = $urandom_range(40, 200);
            pick = $urandom_range(0, 9);
            if (pick == 0) period_val = 32'd0;
            else if (pick < 3) period_val = 32'd1;
            else period_val = $urandom_range(2, 12);
            write_register(ths_pkg::REG_TIMEOUT, timeout_val);
            write_register(ths_pkg::REG_PERIOD, period_val);
            write_register(ths_pkg::REG_WDG_RDY, 32'($urandom_range(0, 3) != 0));
            phase_len = $urandom_range(120, 240);
            for (int n = 0; n < phase_len && counted < 1430; n++) begin
                if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_request(ths_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
                end else if (pick < 78) begin
                    send_request(ths_pkg::CMD_BEAT,
                                 8'($urandom_range(0, ths_pkg::SLOTS - 1)));
                end else if (pick < 88) begin
                    send_request(ths_pkg::CMD_UNREG,
                                 8'($urandom_range(0, ths_pkg::SLOTS - 1)));
                end else if (pick < 95) begin
                    send_request(($urandom_range(0, 1) != 0) ? ths_pkg::CMD_BEAT
                                                             : ths_pkg::CMD_UNREG,
                                 8'($urandom_range(ths_pkg::SLOTS, 255)));
                end else begin
                    send_request(CMD_UNUSED, 8'($urandom_range(0, 255)));
                end
                counted++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin : result_checker
        int stall;
        t_outcome seen;
        t_outcome want;
        @(posedge i_rst_n);
        forever begin
            stall = gaps_on ? $urandom_range(0, 10) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            seen = {o_check_done, o_refresh, o_stale_found, o_stale_slot, o_slot_ignored};
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("unexpected result: done=%0b refresh=%0b stale=%0b",
                             seen.check_done, seen.refresh, seen.stale_found,
                             " slot=%0d ign=%0b", seen.stale_slot, seen.slot_ignored);
            end else begin
                want = pending_outcomes.pop_front();
                if (seen.check_done !== want.check_done || seen.refresh !== want.refresh ||
                    seen.stale_found !== want.stale_found ||
                    seen.stale_slot !== want.stale_slot ||
                    seen.slot_ignored !== want.slot_ignored) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("mismatch: exp done=%0b refresh=%0b stale=%0b slot=%0d ign=%0b,",
                                 want.check_done, want.refresh, want.stale_found,
                                 want.stale_slot, want.slot_ignored,
                                 " got done=%0b refresh=%0b stale=%0b slot=%0d ign=%0b",
                                 seen.check_done, seen.refresh, seen.stale_found,
                                 seen.stale_slot, seen.slot_ignored);
                end
            end
        end
    end

    initial begin
        now_ms = '0;
        ticks_since_check = '0;
        for (int i = 0; i < ths_pkg::SLOTS; i++) begin
            last_beat[i] = '0;
            slot_armed[i] = 1'b0;
        end
        cfg_timeout = ths_pkg::TIMEOUT_RST;
        cfg_period = ths_pkg::PERIOD_RST;
        cfg_wdg_ready = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_beat_at_time_zero();
        test_ignored_requests();
        test_zero_timeout_and_period();
        test_period_shortened();
        test_random_traffic();
        drain_outcomes();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4_800_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
